### design/binomial_tree_option_pricer_top_defines.svh
// Assertion macros for the binomial tree pricer.
`ifndef BINOMIAL_TREE_OPTION_PRICER_TOP_DEFINES_SVH
`define BINOMIAL_TREE_OPTION_PRICER_TOP_DEFINES_SVH
// Assert a property on the rising clock, held off during reset.
`define BTOP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Assert a property on the rising clock, checked in reset too.
`define BTOP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`endif

### design/btop_pkg.sv
`default_nettype none
package btop_pkg;
    localparam int PRICE_W  = 48;
    localparam int FACTOR_W = 32;
    localparam int STEPS_W  = 11;
    localparam int MAX_STEPS_DEFAULT = 1024;
    localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};

    typedef logic [PRICE_W-1:0]  t_price;
    typedef logic [FACTOR_W-1:0] t_factor;

    // Round to nearest, ties up: (a*b + 2^(s-1)) >> s, s in 28 or 31.
    function automatic logic [PRICE_W+FACTOR_W-1:0] round_shift(
        input logic [PRICE_W+FACTOR_W-1:0] prod, input logic sel_w);
        logic [PRICE_W+FACTOR_W:0] t;
        begin
            if (sel_w) begin
                t = {1'b0, prod} + (81'd1 << 30);
                round_shift = (PRICE_W+FACTOR_W)'(t[PRICE_W+FACTOR_W:31]);
            end else begin
                t = {1'b0, prod} + (81'd1 << 27);
                round_shift = (PRICE_W+FACTOR_W)'(t[PRICE_W+FACTOR_W:28]);
            end
        end
    endfunction

    function automatic t_price exercise(input t_price spot, input t_price strike,
                                        input logic put);
        begin
            if (put) exercise = (strike > spot) ? strike - spot : '0;
            else     exercise = (spot > strike) ? spot - strike : '0;
        end
    endfunction
endpackage
`default_nettype wire

### design/binomial_tree_option_pricer_top.sv
// Each word builds n+1 leaves and then runs n*(n+1)/2 node updates before its result,
// n = tree_steps (clamped 1..MAX_STEPS).
// One word at a time: o_in_stall stays high from accept until the result is taken,
// and the next word can be accepted in the cycle after that.
// One shared multiplier and the value/spot memories set the cycle count.
// Synchronous active-low reset clears the sequencer, valid flag and tree_steps (to 1).
`default_nettype none
module binomial_tree_option_pricer_top #(
    parameter int MAX_STEPS = btop_pkg::MAX_STEPS_DEFAULT
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [10:0]  i_cfg_wdata,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire [47:0]  i_lowest_leaf_spot,
    input  wire [31:0]  i_up_over_down,
    input  wire [31:0]  i_inv_down,
    input  wire [31:0]  i_weight_down,
    input  wire [31:0]  i_weight_up,
    input  wire [47:0]  i_strike_price,
    input  wire         i_is_put,
    input  wire         i_is_american,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [47:0] o_option_value,
    output logic        o_status
);
    localparam int AW = $clog2(MAX_STEPS + 1);
    localparam int CW = AW + 1;
    localparam logic [3:0] S_IDLE = 4'd0, S_LEAF = 4'd1, S_LW = 4'd2,
        S_RD = 4'd3, S_M0 = 4'd4, S_M1 = 4'd5, S_M2 = 4'd6, S_M3 = 4'd7,
        S_M4 = 4'd8, S_WR = 4'd9, S_OUT = 4'd10, S_LM = 4'd11;

    logic [3:0] r_state, n_state;
    logic [10:0] r_steps;
    logic [CW-1:0] r_n, r_level, r_j;
    logic [47:0] r_spot, r_strike, r_sp, r_acc;
    logic [48:0] r_term;
    logic [31:0] r_uod, r_invd, r_wd, r_wu;
    logic r_put, r_amer, r_sat;
    logic [47:0] r_val;
    logic [47:0] mem_val [0:MAX_STEPS];
    logic [47:0] mem_spot[0:MAX_STEPS];
    logic [47:0] r_rd_v0, r_rd_v1, r_rd_sp;
    logic [47:0] mul_a;
    logic [31:0] mul_b;
    logic [79:0] prod, rs;
    logic [CW-1:0] steps_cl;
    logic [49:0] sum;

    btop_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(prod));

    always_comb begin
        if (r_steps == 11'd0) steps_cl = CW'(1);
        else if (32'(r_steps) > MAX_STEPS) steps_cl = CW'(MAX_STEPS);
        else steps_cl = CW'(r_steps);
    end

    always_comb begin
        unique case (r_state)
            S_M0:    begin mul_a = r_rd_v0; mul_b = r_wd;   end
            S_M1:    begin mul_a = r_rd_v1; mul_b = r_wu;   end
            S_M2:    begin mul_a = r_rd_sp; mul_b = r_invd; end
            default: begin mul_a = r_spot;  mul_b = r_uod;  end
        endcase
    end

    assign rs = btop_pkg::round_shift(prod, r_state == S_M1 || r_state == S_M2);
    assign sum = 50'(r_term) + 50'(rs[48:0]);

    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_option_value = r_val;
    assign o_status = r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_steps <= 11'd1;
        else if (i_cfg_we) r_steps <= i_cfg_wdata;
    end

    always_ff @(posedge i_clk) begin
        r_rd_v0 <= mem_val[r_j[AW-1:0]];
        r_rd_v1 <= mem_val[(r_j[AW-1:0] == AW'(MAX_STEPS)) ? '0 : r_j[AW-1:0] + AW'(1)];
        r_rd_sp <= mem_spot[r_j[AW-1:0]];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_LW;
            S_LW:   n_state = (r_j == r_n) ? S_RD : S_LEAF;
            S_LEAF: n_state = S_LM;
            S_LM:   n_state = S_LW;
            S_RD:   n_state = S_M0;
            S_M0:   n_state = S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_M4;
            S_M4:   n_state = S_WR;
            S_WR:   n_state = (r_j + CW'(1) == r_level && r_level == CW'(1)) ? S_OUT : S_RD;
            S_OUT:  if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                r_spot <= i_lowest_leaf_spot; r_uod <= i_up_over_down;
                r_invd <= i_inv_down; r_wd <= i_weight_down; r_wu <= i_weight_up;
                r_strike <= i_strike_price; r_put <= i_is_put; r_amer <= i_is_american;
                r_n <= steps_cl; r_level <= steps_cl; r_j <= '0; r_sat <= 1'b0;
            end
            S_LW: begin
                mem_spot[r_j[AW-1:0]] <= r_spot;
                mem_val[r_j[AW-1:0]] <= btop_pkg::exercise(r_spot, r_strike, r_put);
                if (r_j == r_n) r_j <= '0;
            end
            S_LM: begin
                if (rs > 80'(btop_pkg::PRICE_MAX)) begin
                    r_spot <= btop_pkg::PRICE_MAX; r_sat <= 1'b1;
                end else r_spot <= rs[47:0];
                r_j <= r_j + CW'(1);
            end
            S_M1: r_term <= rs[48:0];
            S_M2: begin
                if (sum > 50'(btop_pkg::PRICE_MAX)) begin
                    r_acc <= btop_pkg::PRICE_MAX; r_sat <= 1'b1;
                end else r_acc <= sum[47:0];
            end
            S_M3: if (r_amer) begin
                if (rs > 80'(btop_pkg::PRICE_MAX)) begin
                    r_sp <= btop_pkg::PRICE_MAX; r_sat <= 1'b1;
                end else r_sp <= rs[47:0];
            end
            S_WR: begin
                if (r_amer) begin
                    mem_spot[r_j[AW-1:0]] <= r_sp;
                    if (btop_pkg::exercise(r_sp, r_strike, r_put) > r_acc)
                        r_acc <= btop_pkg::exercise(r_sp, r_strike, r_put);
                end
                mem_val[r_j[AW-1:0]] <= (r_amer &&
                    btop_pkg::exercise(r_sp, r_strike, r_put) > r_acc) ?
                    btop_pkg::exercise(r_sp, r_strike, r_put) : r_acc;
                r_val <= (r_amer && btop_pkg::exercise(r_sp, r_strike, r_put) > r_acc) ?
                    btop_pkg::exercise(r_sp, r_strike, r_put) : r_acc;
                if (r_j + CW'(1) == r_level) begin
                    r_j <= '0; r_level <= r_level - CW'(1);
                end else r_j <= r_j + CW'(1);
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

### design/btop_mul.sv
`default_nettype none
// Shared 48x32 multiplier: two 24x32 partial products, registered, then summed.
module btop_mul (
    input  wire                         i_clk,
    input  wire [btop_pkg::PRICE_W-1:0]  i_a,
    input  wire [btop_pkg::FACTOR_W-1:0] i_b,
    output logic [btop_pkg::PRICE_W+btop_pkg::FACTOR_W-1:0] o_p
);
    logic [55:0] r_hi;
    logic [55:0] r_lo;
    always_ff @(posedge i_clk) begin
        r_hi <= 56'(i_a[47:24]) * 56'(i_b);
        r_lo <= 56'(i_a[23:0]) * 56'(i_b);
    end
    assign o_p = {r_hi, 24'd0} + 80'(r_lo);
endmodule
`default_nettype wire

### design/btop_checker.sv
`default_nettype none
`include "binomial_tree_option_pricer_top_defines.svh"
module btop_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_stall,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [47:0] o_option_value,
    input wire        o_status
);
    `BTOP_ASSERT(a_busy_after_accept, i_in_valid && !o_in_stall |=> o_in_stall, "accept did not raise stall")
    `BTOP_ASSERT(a_no_out_while_idle, o_out_valid |-> o_in_stall, "result shown while idle")
    `BTOP_ASSERT(a_out_holds, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_option_value) && $stable(o_status), "stalled result changed")
    `BTOP_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid, "valid after reset")
endmodule
bind binomial_tree_option_pricer_top btop_checker u_btop_checker (.*);
`default_nettype wire

### dv/binomial_tree_option_pricer_top_tb.sv
`default_nettype none
module binomial_tree_option_pricer_top_tb;

    typedef struct packed {
        btop_pkg::t_price  spot;
        btop_pkg::t_factor uod;
        btop_pkg::t_factor invd;
        btop_pkg::t_factor wd;
        btop_pkg::t_factor wu;
        btop_pkg::t_price  strike;
        logic    put;
        logic    amer;
    } t_option;

    typedef struct packed {
        btop_pkg::t_price value;
        logic   status;
    } t_root;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [10:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [47:0] i_lowest_leaf_spot = '0;
    logic [31:0] i_up_over_down = '0;
    logic [31:0] i_inv_down = '0;
    logic [31:0] i_weight_down = '0;
    logic [31:0] i_weight_up = '0;
    logic [47:0] i_strike_price = '0;
    logic        i_is_put = 1'b0;
    logic        i_is_american = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [47:0] o_option_value;
    logic        o_status;

    binomial_tree_option_pricer_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_lowest_leaf_spot(i_lowest_leaf_spot), .i_up_over_down(i_up_over_down),
        .i_inv_down(i_inv_down), .i_weight_down(i_weight_down),
        .i_weight_up(i_weight_up), .i_strike_price(i_strike_price),
        .i_is_put(i_is_put), .i_is_american(i_is_american),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_option_value(o_option_value), .o_status(o_status)
    );

    always #6 i_clk = ~i_clk;

    localparam int MAX_TREE = 1024;
    localparam longint IDLE_LIMIT = 64'd16000000;

    t_root      roots_due[$];
    btop_pkg::t_price leaf_val[0:MAX_TREE];
    btop_pkg::t_price leaf_spot[0:MAX_TREE];
    logic [10:0] steps_reg = 11'd1;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    int         hold_cycles = 0;
    int         errors = 0;
    int         words_in = 0;
    int         words_out = 0;
    longint     idle_count = 0;
    logic       sat_flag;

    function automatic logic [80:0] round_mul(btop_pkg::t_price a, btop_pkg::t_factor b,
                                              int s);
        logic [80:0] p;
        p = {33'd0, a} * {49'd0, b};
        p = p + (81'd1 << (s - 1));
        return p >> s;
    endfunction

    function automatic btop_pkg::t_price clamp_price(logic [80:0] v);
        if (v > {33'd0, btop_pkg::PRICE_MAX}) begin
            sat_flag = 1'b1;
            return btop_pkg::PRICE_MAX;
        end
        return v[47:0];
    endfunction

    function automatic btop_pkg::t_price payoff(btop_pkg::t_price spot,
                                                btop_pkg::t_price strike, logic put);
        if (put) return (strike > spot) ? strike - spot : '0;
        return (spot > strike) ? spot - strike : '0;
    endfunction

    function automatic t_root price_option(t_option o);
        int n;
        btop_pkg::t_price v;
        btop_pkg::t_price ex;
        t_root r;
        n = steps_reg;
        if (n < 1) n = 1;
        if (n > MAX_TREE) n = MAX_TREE;
        sat_flag = 1'b0;
        leaf_spot[0] = o.spot;
        leaf_val[0] = payoff(o.spot, o.strike, o.put);
        for (int j = 1; j <= n; j++) begin
            leaf_spot[j] = clamp_price(round_mul(leaf_spot[j-1], o.uod, 28));
            leaf_val[j] = payoff(leaf_spot[j], o.strike, o.put);
        end
        for (int lvl = n; lvl > 0; lvl--) begin
            for (int j = 0; j < lvl; j++) begin
                v = clamp_price(round_mul(leaf_val[j], o.wd, 31)
                                + round_mul(leaf_val[j+1], o.wu, 31));
                if (o.amer) begin
                    leaf_spot[j] = clamp_price(round_mul(leaf_spot[j], o.invd, 28));
                    ex = payoff(leaf_spot[j], o.strike, o.put);
                    if (ex > v) v = ex;
                end
                leaf_val[j] = v;
            end
        end
        r.value = leaf_val[0];
        r.status = sat_flag;
        return r;
    endfunction

    // receiver: long hold-off when asked, else random stall
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_root want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_out++;
            if (roots_due.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: value %h status %b",
                         $time, o_option_value, o_status);
            end else begin
                want = roots_due.pop_front();
                if (o_option_value !== want.value) begin
                    errors++;
                    $display("%0t: option_value expected %h actual %h",
                             $time, want.value, o_option_value);
                end
                if (o_status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %b actual %b",
                             $time, want.status, o_status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_word(t_option o);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_lowest_leaf_spot <= o.spot;
        i_up_over_down <= o.uod;
        i_inv_down <= o.invd;
        i_weight_down <= o.wd;
        i_weight_up <= o.wu;
        i_strike_price <= o.strike;
        i_is_put <= o.put;
        i_is_american <= o.amer;
        do @(posedge i_clk); while (o_in_stall);
        roots_due.push_back(price_option(o));
        words_in++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (roots_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_steps(logic [10:0] n);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        steps_reg = n;
    endtask

    function automatic t_option rand_option();
        t_option o;
        o.spot = 48'({$urandom, $urandom});
        o.uod = $urandom;
        o.invd = $urandom;
        o.wd = $urandom;
        o.wu = $urandom;
        o.strike = 48'({$urandom, $urandom});
        o.put = 1'($urandom_range(1));
        o.amer = 1'($urandom_range(1));
        if ($urandom_range(9) < 8) begin
            o.spot = {16'($urandom_range(255)), 8'd0, 24'(o.spot)} + (48'd1 << 28);
            o.strike = o.spot + {24'd0, 2'($urandom_range(3)), 22'(o.strike)}
                       - (48'd3 << 22);
            o.uod = 32'h1000_0000 + $urandom_range(32'h0400_0000);
            o.invd = 32'h1000_0000 + $urandom_range(32'h0200_0000);
            o.wd = 32'h3800_0000 + $urandom_range(32'h1000_0000);
            o.wu = 32'h3800_0000 + $urandom_range(32'h1000_0000);
        end
        return o;
    endfunction

    task automatic test_directed();
        t_option b;
        t_option o;
        b = '{spot: 48'd100 << 24, uod: 32'h1200_0000, invd: 32'h1080_0000,
              wd: 32'h4000_0000, wu: 32'h3f00_0000, strike: 48'd110 << 24,
              put: 1'b0, amer: 1'b0};
        write_steps(11'd3);
        for (int k = 0; k < 4; k++) begin
            o = b; o.put = k[0]; o.amer = k[1];
            send_word(o);
        end
        o = b; o.spot = '0; o.put = 1'b1; o.amer = 1'b1; send_word(o);
        o = b; o.strike = '0; send_word(o);
        o = b; o.spot = btop_pkg::PRICE_MAX; send_word(o);
        o = b; o.strike = btop_pkg::PRICE_MAX; o.put = 1'b1; o.amer = 1'b1; send_word(o);
        o = b; o.wd = 32'h8000_0000; o.wu = 32'h8000_0000; send_word(o);
        o = b; o.wd = '1; o.wu = '1; send_word(o);
        o = b; o.wd = '0; o.wu = '0; send_word(o);
        o = b; o.uod = '1; o.amer = 1'b1; send_word(o);
        o = b; o.uod = '0; o.invd = '0; o.put = 1'b1; o.amer = 1'b1; send_word(o);
        o = b; o.invd = '1; o.put = 1'b1; o.amer = 1'b1; send_word(o);
    endtask

    task automatic test_step_limits();
        write_steps(11'd0);
        repeat (4) send_word(rand_option());
        write_steps(11'd1);
        repeat (4) send_word(rand_option());
        write_steps(11'd2047);
        send_word(rand_option());
    endtask

    task automatic test_random(int send_pct, int recv_pct, int count);
        write_steps(11'($urandom_range(12, 1)));
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
        repeat (count) begin
            if ($urandom_range(7) == 0) write_steps(11'($urandom_range(24, 1)));
            send_word(rand_option());
        end
    endtask

    task automatic test_backpressure();
        write_steps(11'd4);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 3000;
        repeat (6) send_word(rand_option());
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_step_limits();
        test_random(0, 0, 15);
        test_random(57, 0, 15);
        test_random(0, 57, 15);
        test_random(57, 57, 15);
        test_random(15, 15, 15);
        test_backpressure();
        drain();
        $display("Ran %0d option words, %0d results, tree steps 0 to 2047 incl. clamp,",
                 words_in, words_out);
        $display("calls/puts, European/American, saturating inputs and random idling.");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
